FILE: sv/assert_macros.svh
// Assertion helpers shared by the search unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHECK_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mbps_pkg.sv
package mbps_pkg;

  // Width of a cell slot number; covers the largest supported chain.
  localparam int unsigned SLOT_W = 8;

  // Operation codes of an input item.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SCAN  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [5:0] entry_index;
    logic [7:0] entry_byte;
    logic       entry_wild;
    logic [7:0] data_byte;
    logic       data_last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_offset;
  } out_item_t;

  // Pattern load into one cell of the chain.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        pbyte;
    logic              wild;
  } cell_wr_t;

endpackage

FILE: sv/mbps_cell.sv
module mbps_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  logic [7:0]         byte_in,
  output logic [7:0]         byte_out,
  input  mbps_pkg::cell_wr_t wr,
  input  logic               active,
  output logic               hit
);

  localparam logic [mbps_pkg::SLOT_W-1:0] MY_SLOT = INDEX[mbps_pkg::SLOT_W-1:0];

  logic [7:0] win_r;
  logic [7:0] pat_byte_r;
  logic       pat_wild_r;

  // Advance the window byte to the next cell on each scanned byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift_en) begin
      win_r <= byte_in;
    end
  end

  // Load the pattern entry aligned to this window position
  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot == MY_SLOT)) begin
      pat_byte_r <= wr.pbyte;
      pat_wild_r <= wr.wild;
    end
  end

  assign byte_out = win_r;

  // Compare the byte that takes this position on the current shift
  assign hit = !active || pat_wild_r || (pat_byte_r == byte_in);

endmodule

FILE: sv/mbps_obuf.sv
`include "assert_macros.svh"

module mbps_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbps_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output mbps_pkg::out_item_t out_data
);

  logic                head_v_r, head_v_nxt;
  logic                skid_v_r, skid_v_nxt;
  mbps_pkg::out_item_t head_r, head_nxt;
  mbps_pkg::out_item_t skid_r, skid_nxt;
  logic                pop;
  logic                head_v_mid;

  assign pop = head_v_r && !out_stall;

  // Drop the head on a transfer, then place a new result in the first free slot
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      head_v_nxt = skid_v_r;
      head_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end
    head_v_mid = head_v_nxt;
    if (push) begin
      if (!head_v_mid) begin
        head_v_nxt = 1'b1;
        head_nxt   = push_item;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

  `CHECK_ALWAYS(a_skid_needs_head, clk, rst_n, !skid_v_r || head_v_r, "skid holds a result without a head")
  `CHECK_ALWAYS(a_no_push_full, clk, rst_n, !(push && skid_v_r), "result pushed into a full buffer")
  `CHECK_NEXT(a_skid_moves_up, clk, rst_n, pop && skid_v_r, head_v_r && !skid_v_r, "skid result lost on transfer")

endmodule

FILE: sv/masked_byte_pattern_search_unit.sv
// Masked byte pattern search unit.
// Input channel in_valid / in_stall / in_data: an item with operation write
// loads one pattern entry (byte plus wildcard flag); an item with operation
// scan shifts one region byte into a chain of MAX_PATTERN compare cells, and
// data_last marks the region's final byte. One item is taken per cycle while in_stall is low.
// Result channel out_valid / out_stall / out_data: one result per region,
// pushed into the output buffer as its last byte is taken, with found and the
// start offset of the first match. A two-entry output buffer lets scanning
// go on while a result waits; in_stall also rises when both entries are held.
// Configuration: cfg_we with cfg_wdata sets pattern_length. Each write starts
// a realign pass that copies the pattern memory into the cells through its
// single read port, one entry a cycle, for min(pattern_length, MAX_PATTERN)
// entries; in_stall stays high during that pass.
// Reset clears the window, byte count, match state and output buffer and
// sets pattern_length to 0; pattern entries stay undefined until written.
// A stalled receiver holds results in the buffer; once it is full the input
// side stalls until a transfer frees an entry.
`include "assert_macros.svh"

module masked_byte_pattern_search_unit #(
  parameter int unsigned MAX_PATTERN = 64,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mbps_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CMP_W = (OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W;
  localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

  logic [6:0]             len_cfg_r;
  logic [LEN_W-1:0]       len_eff;
  logic                   ob_full;
  logic                   busy;
  logic                   in_acc;
  logic                   is_write;
  logic                   is_scan;
  logic                   idx_ok;
  logic                   idx_in_len;
  logic [LEN_W-1:0]       wr_pos;

  logic [8:0]             pat_mem [MAX_PATTERN];
  logic [8:0]             mem_q_r;
  logic                   sw_run_r;
  logic [LEN_W-1:0]       sw_cnt_r;
  logic                   rd_v_r;
  logic [mbps_pkg::SLOT_W-1:0] rd_slot_r;
  logic [LEN_W-1:0]       sw_pos;

  mbps_pkg::cell_wr_t     cell_wr;
  logic [7:0]             chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] active;
  logic [MAX_PATTERN-1:0] hit;
  logic                   all_hit;

  logic [OFFSET_BITS-1:0] cnt_r;
  logic                   seen_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic                   counted;
  logic [OFFSET_BITS-1:0] count_new;
  logic                   long_enough;
  logic                   match_new;
  logic                   seen_nxt;
  logic [OFFSET_BITS-1:0] off_nxt;
  logic                   push;
  mbps_pkg::out_item_t    push_item;

  // Clamp the pattern length to the chain size
  assign len_eff = (32'(len_cfg_r) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(len_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= '0;
    end else if (cfg_we) begin
      len_cfg_r <= cfg_wdata;
    end
  end

  // Input transfer decode
  assign busy     = sw_run_r || rd_v_r;
  assign in_stall = busy || ob_full;
  assign in_acc   = in_valid && !in_stall;
  assign is_write = in_acc && (in_data.operation == mbps_pkg::OP_WRITE);
  assign is_scan  = in_acc && (in_data.operation == mbps_pkg::OP_SCAN);
  assign idx_ok     = {26'd0, in_data.entry_index} < 32'(MAX_PATTERN);
  assign idx_in_len = {26'd0, in_data.entry_index} < 32'(len_eff);
  assign wr_pos     = len_eff - LEN_W'(1) - LEN_W'(in_data.entry_index);

  // Keep the pattern in memory by entry index
  always_ff @(posedge clk) begin
    if (is_write && idx_ok) begin
      pat_mem[IDX_W'(in_data.entry_index)] <= {in_data.entry_wild, in_data.entry_byte};
    end
    mem_q_r <= pat_mem[sw_cnt_r[IDX_W-1:0]];
  end

  // Realign pass: copy entry j into the cell at window age len-1-j
  assign sw_pos = len_eff - LEN_W'(1) - sw_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_run_r <= 1'b0;
      sw_cnt_r <= '0;
      rd_v_r   <= 1'b0;
    end else begin
      rd_v_r <= sw_run_r && (sw_cnt_r < len_eff);
      if (cfg_we) begin
        sw_run_r <= 1'b1;
        sw_cnt_r <= '0;
      end else if (sw_run_r) begin
        if (sw_cnt_r < len_eff) begin
          sw_cnt_r <= sw_cnt_r + LEN_W'(1);
        end else begin
          sw_run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= mbps_pkg::SLOT_W'(sw_pos);
  end

  // Route either the realign copy or a direct pattern write to the cells
  always_comb begin
    cell_wr = '0;
    if (rd_v_r) begin
      cell_wr.en    = 1'b1;
      cell_wr.slot  = rd_slot_r;
      cell_wr.pbyte = mem_q_r[7:0];
      cell_wr.wild  = mem_q_r[8];
    end else if (is_write && idx_in_len) begin
      cell_wr.en    = 1'b1;
      cell_wr.slot  = mbps_pkg::SLOT_W'(wr_pos);
      cell_wr.pbyte = in_data.entry_byte;
      cell_wr.wild  = in_data.entry_wild;
    end
  end

  // Compare chain: cell k sees the byte that becomes window age k
  assign chain[0] = in_data.data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign active[k] = LEN_W'(k) < len_eff;
    if (k < MAX_PATTERN - 1) begin : g_mid
      mbps_cell #(.INDEX(k)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (is_scan),
        .byte_in  (chain[k]),
        .byte_out (chain[k+1]),
        .wr       (cell_wr),
        .active   (active[k]),
        .hit      (hit[k])
      );
    end else begin : g_end
      mbps_cell #(.INDEX(k)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (is_scan),
        .byte_in  (chain[k]),
        .byte_out (),
        .wr       (cell_wr),
        .active   (active[k]),
        .hit      (hit[k])
      );
    end
  end

  assign all_hit = &hit;

  // Count region bytes and record the first match
  assign counted     = cnt_r != CNT_MAX;
  assign count_new   = counted ? (cnt_r + OFFSET_BITS'(1)) : cnt_r;
  assign long_enough = CMP_W'(count_new) >= CMP_W'(len_eff);
  assign match_new   = !seen_r &&
                       ((len_eff == '0) || (counted && long_enough && all_hit));
  assign seen_nxt    = seen_r || match_new;

  always_comb begin
    off_nxt = off_r;
    if (match_new) begin
      if (len_eff == '0) begin
        off_nxt = '0;
      end else begin
        off_nxt = count_new - OFFSET_BITS'(len_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      seen_r <= 1'b0;
      off_r  <= '0;
    end else if (is_scan) begin
      if (in_data.data_last) begin
        cnt_r  <= '0;
        seen_r <= 1'b0;
        off_r  <= '0;
      end else begin
        cnt_r  <= count_new;
        seen_r <= seen_nxt;
        off_r  <= off_nxt;
      end
    end
  end

  // Report on the region's last byte
  assign push                   = is_scan && in_data.data_last;
  assign push_item.found        = seen_nxt;
  assign push_item.match_offset = seen_nxt ? 32'(off_nxt) : 32'd0;

  mbps_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (ob_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `CHECK_NEXT(a_cfg_starts_pass, clk, rst_n, cfg_we, sw_run_r, "length write did not start realign")
  `CHECK_NEXT(a_last_gives_result, clk, rst_n, push, out_valid, "region end produced no result")
  `CHECK_ALWAYS(a_idle_during_pass, clk, rst_n, !(rd_v_r && is_write), "pattern write during realign")

endmodule
